// ===== rtl/tun_pkg.sv =====
package tun_pkg;

  localparam int TUN_COORD_BITS = 24;
  localparam int TUN_FRAC_BITS  = 30;
  localparam int TUN_OUT_BITS   = 32;

  // pipeline control handed to the sub-pipelines
  typedef struct packed {
    logic adv;    // all stages move one step
    logic valid;  // word present at the stage input
  } tun_ctl_t;

endpackage

// ===== rtl/tun_if.sv =====
interface tun_in_if import tun_pkg::*; #(
  parameter int COORD_BITS = TUN_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] p0_x;
  logic signed [COORD_BITS-1:0] p0_y;
  logic signed [COORD_BITS-1:0] p0_z;
  logic signed [COORD_BITS-1:0] p1_x;
  logic signed [COORD_BITS-1:0] p1_y;
  logic signed [COORD_BITS-1:0] p1_z;
  logic signed [COORD_BITS-1:0] p2_x;
  logic signed [COORD_BITS-1:0] p2_y;
  logic signed [COORD_BITS-1:0] p2_z;

  modport source (output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                  input ready);
  modport sink   (input valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z,
                  output ready);
endinterface

interface tun_out_if import tun_pkg::*;;
  logic                           valid;
  logic                           ready;
  logic signed [TUN_OUT_BITS-1:0] unit_x;
  logic signed [TUN_OUT_BITS-1:0] unit_y;
  logic signed [TUN_OUT_BITS-1:0] unit_z;
  logic                           degenerate;

  modport source (output valid, unit_x, unit_y, unit_z, degenerate, input ready);
  modport sink   (input valid, unit_x, unit_y, unit_z, degenerate, output ready);
endinterface

// ===== rtl/triangle_unit_normal.sv =====
// Throughput: one word per cycle; the square root and the dividers are fully
// pipelined, one bit per stage, and every stage holds while the output word stalls.
// Reset (rst, synchronous) clears all stage valid bits; payload registers keep
// whatever they hold.
module triangle_unit_normal import tun_pkg::*; #(
  parameter int COORD_BITS = TUN_COORD_BITS,
  parameter int FRAC_BITS  = TUN_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst,
  tun_in_if.sink    in_ch,
  tun_out_if.source out_ch
);

  localparam int E  = COORD_BITS + 1;   // edge width
  localparam int P  = 2 * E;            // product width
  localparam int M  = 2 * E;            // cross magnitude width
  localparam int H  = (M + 1) / 2;      // low half of a magnitude
  localparam int L  = M - H;            // high half
  localparam int SQ = 2 * M;            // square width
  localparam int S  = 2 * M + 2;        // sum of squares width
  localparam int R  = M + 1;            // root width
  localparam int Q  = FRAC_BITS + 1;    // quotient width
  localparam int SW = 3 * M + 3;        // side data through the root

  logic     adv;
  tun_ctl_t ctl6;
  tun_ctl_t ctl_d;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  // stage 1: edge vectors
  logic                v1;
  logic signed [E-1:0] x1, y1, z1, x2, y2, z2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      x1 <= E'(in_ch.p1_x) - E'(in_ch.p0_x);
      y1 <= E'(in_ch.p1_y) - E'(in_ch.p0_y);
      z1 <= E'(in_ch.p1_z) - E'(in_ch.p0_z);
      x2 <= E'(in_ch.p2_x) - E'(in_ch.p0_x);
      y2 <= E'(in_ch.p2_y) - E'(in_ch.p0_y);
      z2 <= E'(in_ch.p2_z) - E'(in_ch.p0_z);
    end
  end

  // stage 2: six products of the cross product
  logic                v2;
  logic signed [P-1:0] pa [0:2];
  logic signed [P-1:0] pb [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pa[0] <= y1 * z2;
      pb[0] <= z1 * y2;
      pa[1] <= z1 * x2;
      pb[1] <= x1 * z2;
      pa[2] <= x1 * y2;
      pb[2] <= y1 * x2;
    end
  end

  // stage 3: components as sign and magnitude
  logic         v3;
  logic [M-1:0] mg3 [0:2];
  logic         sg3 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  genvar c;
  for (c = 0; c < 3; c++) begin : g_comp
    logic signed [P:0] diff;
    logic        [P:0] amag;

    always_comb begin
      diff = (P+1)'(pa[c]) - (P+1)'(pb[c]);
      amag = diff[P] ? (P+1)'(-diff) : (P+1)'(diff);
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        mg3[c] <= amag[M-1:0];
        sg3[c] <= diff[P];
      end
    end
  end

  // stage 4: partial products of each square
  logic           v4;
  logic [2*L-1:0] hh [0:2];
  logic [L+H-1:0] hl [0:2];
  logic [2*H-1:0] ll [0:2];
  logic [M-1:0]   mg4 [0:2];
  logic           sg4 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
  end

  for (c = 0; c < 3; c++) begin : g_part
    always_ff @(posedge clk) begin
      if (adv) begin
        hh[c]  <= mg3[c][M-1:H] * mg3[c][M-1:H];
        hl[c]  <= mg3[c][M-1:H] * mg3[c][H-1:0];
        ll[c]  <= mg3[c][H-1:0] * mg3[c][H-1:0];
        mg4[c] <= mg3[c];
        sg4[c] <= sg3[c];
      end
    end
  end

  // stage 5: assemble squares
  logic          v5;
  logic [SQ-1:0] sq5 [0:2];
  logic [M-1:0]  mg5 [0:2];
  logic          sg5 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
  end

  for (c = 0; c < 3; c++) begin : g_sq
    always_ff @(posedge clk) begin
      if (adv) begin
        sq5[c] <= (SQ'(hh[c]) << (2 * H)) + (SQ'(hl[c]) << (H + 1)) + SQ'(ll[c]);
        mg5[c] <= mg4[c];
        sg5[c] <= sg4[c];
      end
    end
  end

  // stage 6: sum of squares
  logic          v6;
  logic [S-1:0]  sum6;
  logic [M-1:0]  mg6 [0:2];
  logic          sg6 [0:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sum6 <= S'(sq5[0]) + S'(sq5[1]) + S'(sq5[2]);
      for (int i = 0; i < 3; i++) begin
        mg6[i] <= mg5[i];
        sg6[i] <= sg5[i];
      end
    end
  end

  // length
  logic          vr;
  logic [R-1:0]  root;
  logic [SW-1:0] side_r;
  logic [M-1:0]  mgr [0:2];
  logic          sgr [0:2];
  logic          degen_r;

  assign ctl6.adv   = adv;
  assign ctl6.valid = v6;

  tun_isqrt_pipe #(
    .RW (R),
    .SW (SW)
  ) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl6),
    .rad       (sum6),
    .side_in   ({mg6[0], mg6[1], mg6[2], sg6[0], sg6[1], sg6[2]}),
    .valid_out (vr),
    .root_out  (root),
    .side_out  (side_r)
  );

  assign {mgr[0], mgr[1], mgr[2], sgr[0], sgr[1], sgr[2]} = side_r;
  assign degen_r = (root == '0);

  // three dividers in lockstep; x carries the degenerate flag
  logic         vd [0:2];
  logic [Q-1:0] qd [0:2];
  logic         ng [0:2];
  logic         dg;
  logic [1:0]   sd0;

  assign ctl_d.adv   = adv;
  assign ctl_d.valid = vr;

  tun_div_pipe #(
    .MW (M), .RW (R), .FB (FRAC_BITS), .SW (2)
  ) u_div_x (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_d),
    .mag       (mgr[0]),
    .len       (root),
    .side_in   ({sgr[0], degen_r}),
    .valid_out (vd[0]),
    .quot      (qd[0]),
    .side_out  (sd0)
  );

  assign {ng[0], dg} = sd0;

  tun_div_pipe #(
    .MW (M), .RW (R), .FB (FRAC_BITS), .SW (1)
  ) u_div_y (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_d),
    .mag       (mgr[1]),
    .len       (root),
    .side_in   (sgr[1]),
    .valid_out (vd[1]),
    .quot      (qd[1]),
    .side_out  (ng[1])
  );

  tun_div_pipe #(
    .MW (M), .RW (R), .FB (FRAC_BITS), .SW (1)
  ) u_div_z (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl_d),
    .mag       (mgr[2]),
    .len       (root),
    .side_in   (sgr[2]),
    .valid_out (vd[2]),
    .quot      (qd[2]),
    .side_out  (ng[2])
  );

  // clamp, apply sign, fit to the output width; zero for a degenerate face
  function automatic logic [TUN_OUT_BITS-1:0] to_out(logic [Q-1:0] qv, logic neg,
                                                     logic zero);
    logic [Q-1:0]      lim;
    logic [Q-1:0]      qs;
    logic signed [Q:0] sv;
    lim = Q'(1) << FRAC_BITS;
    qs  = (qv > lim) ? lim : qv;
    sv  = neg ? -$signed({1'b0, qs}) : $signed({1'b0, qs});
    return zero ? '0 : TUN_OUT_BITS'(sv);
  endfunction

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (adv) begin
      out_ch.valid <= vd[0] && vd[1] && vd[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.unit_x     <= to_out(qd[0], ng[0], dg);
      out_ch.unit_y     <= to_out(qd[1], ng[1], dg);
      out_ch.unit_z     <= to_out(qd[2], ng[2], dg);
      out_ch.degenerate <= dg;
    end
  end

endmodule

// ===== rtl/tun_isqrt_pipe.sv =====
// Floor square root, one root bit per stage, side data rides along.
module tun_isqrt_pipe import tun_pkg::*; #(
  parameter int RW = 49,
  parameter int SW = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  tun_ctl_t        ctl,
  input  logic [2*RW-1:0] rad,
  input  logic [SW-1:0]   side_in,
  output logic            valid_out,
  output logic [RW-1:0]   root_out,
  output logic [SW-1:0]   side_out
);

  logic            v    [0:RW];
  logic [RW-1:0]   root [0:RW];
  logic [RW+1:0]   rem  [0:RW];
  logic [2*RW-1:0] rd   [0:RW];
  logic [SW-1:0]   sd   [0:RW];

  assign v[0]    = ctl.valid;
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign rd[0]   = rad;
  assign sd[0]   = side_in;

  genvar k;
  for (k = 0; k < RW; k++) begin : g_stage
    logic [RW+1:0] rem_t;
    logic [RW+1:0] trial;
    logic          ge;

    // bring in two radicand bits, try the next root bit
    always_comb begin
      rem_t = {rem[k][RW-1:0], rd[k][2*RW-1 -: 2]};
      trial = {root[k], 2'b01};
      ge    = (rem_t >= trial);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (ctl.adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rem[k+1]  <= ge ? (rem_t - trial) : rem_t;
        root[k+1] <= {root[k][RW-2:0], ge};
        rd[k+1]   <= rd[k] << 2;
        sd[k+1]   <= sd[k];
      end
    end
  end

  assign valid_out = v[RW];
  assign root_out  = root[RW];
  assign side_out  = sd[RW];

endmodule

// ===== rtl/tun_div_pipe.sv =====
// Restoring divide of (mag << FB) by len, one quotient bit per stage.
// Quotient never exceeds 2^FB since mag <= len, so FB+1 stages cover it.
module tun_div_pipe import tun_pkg::*; #(
  parameter int MW = 48,
  parameter int RW = 49,
  parameter int FB = 30,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic          rst,
  input  tun_ctl_t      ctl,
  input  logic [MW-1:0] mag,
  input  logic [RW-1:0] len,
  input  logic [SW-1:0] side_in,
  output logic          valid_out,
  output logic [FB:0]   quot,
  output logic [SW-1:0] side_out
);

  localparam int Q = FB + 1;

  logic          v   [0:Q];
  logic [RW-1:0] rem [0:Q];
  logic [Q-1:0]  q   [0:Q];
  logic [RW-1:0] ln  [0:Q];
  logic [SW-1:0] sd  [0:Q];
  logic          nb0;

  assign nb0    = mag[0];
  assign v[0]   = ctl.valid;
  assign rem[0] = RW'(mag >> 1);
  assign q[0]   = '0;
  assign ln[0]  = len;
  assign sd[0]  = side_in;

  genvar k;
  for (k = 0; k < Q; k++) begin : g_stage
    logic [RW:0] rem_t;
    logic [RW:0] lx;
    logic        ge;

    // only the first step sees a dividend bit; the rest shift in zeros
    always_comb begin
      rem_t = {rem[k], ((k == 0) ? nb0 : 1'b0)};
      lx    = {1'b0, ln[k]};
      ge    = (rem_t >= lx);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (ctl.adv) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.adv) begin
        rem[k+1] <= ge ? RW'(rem_t - lx) : RW'(rem_t);
        q[k+1]   <= {q[k][Q-2:0], ge};
        ln[k+1]  <= ln[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  assign valid_out = v[Q];
  assign quot      = q[Q];
  assign side_out  = sd[Q];

endmodule

// ===== rtl/tun_checker.sv =====
module tun_checker import tun_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [TUN_OUT_BITS-1:0] unit_x,
  input logic [TUN_OUT_BITS-1:0] unit_y,
  input logic [TUN_OUT_BITS-1:0] unit_z,
  input logic                    degenerate
);

  // a result word waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // input is held off only by a stalled result word
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output backpressure");

  // degenerate faces give a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> unit_x == '0 && unit_y == '0 && unit_z == '0)
    else $error("degenerate word with nonzero components");

  // pipeline empties on reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result word present after reset");

endmodule

bind triangle_unit_normal tun_checker u_tun_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .unit_x     (out_ch.unit_x),
  .unit_y     (out_ch.unit_y),
  .unit_z     (out_ch.unit_z),
  .degenerate (out_ch.degenerate)
);

// ===== tb/triangle_unit_normal_test.sv =====
`timescale 1ns / 100ps

module triangle_unit_normal_test;
  import tun_pkg::*;

  localparam int LATENCY   = 2 * TUN_COORD_BITS + TUN_FRAC_BITS + 11;
  localparam int MAX_CYCLE = 400000;
  localparam int N_RANDOM  = 400;

  typedef logic signed [TUN_COORD_BITS-1:0] coord_t;
  // corner coordinates in the order p0 xyz, p1 xyz, p2 xyz
  typedef coord_t face_t [9];

  typedef struct packed {
    logic [TUN_OUT_BITS-1:0] x;
    logic [TUN_OUT_BITS-1:0] y;
    logic [TUN_OUT_BITS-1:0] z;
    logic                    degen;
  } normal_t;

  class normal_board;
    normal_t pending[$];
    int      errors;

    // exact face normal, scaled to FRAC_BITS and saturated at one
    function normal_t unit_normal(face_t f);
      longint       e[6];
      longint       c[3];
      logic [127:0] m[3];
      logic [127:0] s, len, t, q;
      logic [TUN_OUT_BITS-1:0] comp[3];
      normal_t      r;
      for (int k = 0; k < 3; k++) begin
        e[k]     = longint'(f[3+k]) - longint'(f[k]);
        e[3 + k] = longint'(f[6+k]) - longint'(f[k]);
      end
      c[0] = e[1] * e[5] - e[2] * e[4];
      c[1] = e[2] * e[3] - e[0] * e[5];
      c[2] = e[0] * e[4] - e[1] * e[3];
      s = 0;
      for (int k = 0; k < 3; k++) begin
        m[k] = (c[k] < 0) ? 128'(-c[k]) : 128'(c[k]);
        s = s + m[k] * m[k];
      end
      if (s == 0) begin
        r.x = 0; r.y = 0; r.z = 0; r.degen = 1'b1;
        return r;
      end
      // floor square root, one bit at a time
      len = 0;
      for (int i = 63; i >= 0; i--) begin
        t = len | (128'd1 << i);
        if (t * t <= s) len = t;
      end
      for (int k = 0; k < 3; k++) begin
        q = (m[k] << TUN_FRAC_BITS) / len;
        if (q > (128'd1 << TUN_FRAC_BITS)) q = 128'd1 << TUN_FRAC_BITS;
        comp[k] = (c[k] < 0) ? -q[TUN_OUT_BITS-1:0] : q[TUN_OUT_BITS-1:0];
      end
      r.x = comp[0]; r.y = comp[1]; r.z = comp[2]; r.degen = 1'b0;
      return r;
    endfunction

    function void note_face(face_t f);
      pending.insert(pending.size(), unit_normal(f));
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("mismatch %s: got %h want %h", what, got, want);
    endtask

    task check_normal(normal_t got);
      normal_t want;
      if (pending.size() == 0) begin
        report("unexpected word", got.x, 0);
        return;
      end
      want = pending.pop_front();
      if (got.x !== want.x) report("unit_x", got.x, want.x);
      if (got.y !== want.y) report("unit_y", got.y, want.y);
      if (got.z !== want.z) report("unit_z", got.z, want.z);
      if (got.degen !== want.degen) report("degenerate", got.degen, want.degen);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   cycles = 0;
  normal_board board = new();

  tun_in_if  in_ch();
  tun_out_if out_ch();

  triangle_unit_normal DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #6 clk = ~clk;

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLE) begin
      $display("triangle_unit_normal_test: FAIL");
      $finish;
    end
  end

  // monitor both channels at the rising edge
  always @(posedge clk) begin
    normal_t got;
    if (!rst && in_ch.valid && in_ch.ready) begin
      board.note_face('{in_ch.p0_x, in_ch.p0_y, in_ch.p0_z, in_ch.p1_x, in_ch.p1_y,
                         in_ch.p1_z, in_ch.p2_x, in_ch.p2_y, in_ch.p2_z});
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.x = out_ch.unit_x; got.y = out_ch.unit_y; got.z = out_ch.unit_z;
      got.degen = out_ch.degenerate;
      board.check_normal(got);
    end
  end

  // receiver stall pattern: one of four modes, redrawn at random while the test runs
  int stall_mode = 0;
  always @(negedge clk) begin
    if (cycles % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_ch.ready = 1'b1;
      1: out_ch.ready = ($urandom_range(0, 1) == 1);
      2: out_ch.ready = ($urandom_range(0, 7) == 0);
      default: out_ch.ready = ((cycles / 5) % 2 == 0);
    endcase
  end

  task drive_face(face_t f);
    in_ch.valid = 1'b1;
    in_ch.p0_x = f[0]; in_ch.p0_y = f[1]; in_ch.p0_z = f[2];
    in_ch.p1_x = f[3]; in_ch.p1_y = f[4]; in_ch.p1_z = f[5];
    in_ch.p2_x = f[6]; in_ch.p2_y = f[7]; in_ch.p2_z = f[8];
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    @(negedge clk);
  endtask

  task idle_cycles(int n);
    in_ch.valid = 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function face_t random_face();
    face_t f;
    int    kind;
    longint v;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++) begin
      if (kind < 4) f[k] = coord_t'($urandom);
      else if (kind < 7) f[k] = coord_t'(int'($urandom_range(0, 31)) - 16);
      else f[k] = coord_t'(int'($urandom_range(0, 2047)) - 1024);
    end
    // near-collinear or degenerate: p2 on or close to the p0-p1 line
    if (kind >= 8) begin
      for (int k = 0; k < 3; k++) begin
        v = 2 * longint'(f[3+k]) - longint'(f[k]);
        if (kind == 9) v = v + $urandom_range(0, 2) - 1;
        f[6 + k] = coord_t'(v);
      end
    end
    return f;
  endfunction

  localparam coord_t CMAX = coord_t'(8388607);
  localparam coord_t CMIN = coord_t'(-8388608);

  initial begin
    face_t dir [$];
    face_t f;
    int    sent;
    int    burst;
    in_ch.valid = 1'b0;
    in_ch.p0_x = 0; in_ch.p0_y = 0; in_ch.p0_z = 0;
    in_ch.p1_x = 0; in_ch.p1_y = 0; in_ch.p1_z = 0;
    in_ch.p2_x = 0; in_ch.p2_y = 0; in_ch.p2_z = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed faces
    dir.insert(dir.size(), '{0, 0, 0, 0, 0, 0, 0, 0, 0});        // coincident
    dir.insert(dir.size(), '{1, 2, 3, 2, 4, 6, 3, 6, 9});        // collinear
    dir.insert(dir.size(), '{0, 0, 0, 1, 0, 0, 0, 1, 0});        // +z
    dir.insert(dir.size(), '{0, 0, 0, 0, 1, 0, 1, 0, 0});        // -z
    dir.insert(dir.size(), '{0, 0, 0, 0, 1, 0, 0, 0, 1});        // +x
    dir.insert(dir.size(), '{0, 0, 0, 0, 0, 1, 1, 0, 0});        // +y
    dir.insert(dir.size(), '{0, 0, 0, 1, -1, 0, 0, 1, -1});      // overshoot (1,1,1)
    dir.insert(dir.size(), '{0, 0, 0, -1, 1, 0, 0, -1, 1});      // overshoot (1,1,1), edges negated
    dir.insert(dir.size(), '{CMIN, CMIN, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN});
    dir.insert(dir.size(), '{CMAX, CMAX, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN, CMAX});
    dir.insert(dir.size(), '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMAX, CMIN});
    dir.insert(dir.size(), '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, CMAX});
    dir.insert(dir.size(), '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN});
    dir.insert(dir.size(), '{-1, -1, -1, -1, -1, -1, -1, -1, -1});
    dir.insert(dir.size(), '{5, -7, 3, 5, -7, 3, 9, 1, -2});     // p0 equals p1
    dir.insert(dir.size(), '{0, 0, 0, 3, 4, 0, 0, 0, 12});
    foreach (dir[i]) drive_face(dir[i]);

    // hold off until the pipeline has drained
    idle_cycles(1);
    while (board.pending.size() != 0) @(negedge clk);

    // random bursts with random gaps
    sent = 0;
    while (sent < N_RANDOM) begin
      burst = $urandom_range(1, 24);
      for (int b = 0; b < burst && sent < N_RANDOM; b++) begin
        f = random_face();
        drive_face(f);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 8));
    end
    in_ch.valid = 1'b0;

    while (board.pending.size() != 0) @(negedge clk);
    repeat (2 * LATENCY) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("triangle_unit_normal_test: PASS");
    end else begin
      $display("triangle_unit_normal_test: FAIL");
    end
    $finish;
  end

endmodule
